@@ hw/rtl/rdc_pkg.sv @@
// Package with the request, response and channel state types of the datagram channel core.
`default_nettype none
package rdc_pkg;

	localparam int SEQ_W   = 31;
	localparam int WORD_W  = 32;
	localparam int LEN_W   = 11;
	localparam int COST_W  = 16;
	localparam int CLEAR_W = 48;
	localparam int CHOKE_W = 24;
	localparam int OP_W    = 3;

	localparam int HDR_BYTES      = 8;
	localparam int BACKUP_PACKETS = 200;

	localparam logic [OP_W-1:0] OP_SEND          = 3'd0;
	localparam logic [OP_W-1:0] OP_RECEIVE       = 3'd1;
	localparam logic [OP_W-1:0] OP_CAN_SEND      = 3'd2;
	localparam logic [OP_W-1:0] OP_CAN_SEND_REL  = 3'd3;
	localparam logic [OP_W-1:0] OP_CHAN_RESET    = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [WORD_W-1:0] current_time;
		logic [LEN_W-1:0]  unreliable_length;
		logic [LEN_W-1:0]  pending_length;
		logic              pending_overflowed;
		logic [WORD_W-1:0] seq_word;
		logic [WORD_W-1:0] ack_word;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] out_seq_word;
		logic [WORD_W-1:0] out_ack_word;
		logic [LEN_W-1:0]  packet_length;
		logic              reliable_included;
		logic              unreliable_included;
		logic              pending_taken;
		logic              fatal_error;
		logic [WORD_W-1:0] drop_count;
		logic [WORD_W-1:0] good_count;
		logic [WORD_W-1:0] choke_count;
	} rsp_t;

	typedef struct packed {
		logic [SEQ_W-1:0]   in_seq;
		logic [SEQ_W-1:0]   out_seq;
		logic [SEQ_W-1:0]   last_rel_out_seq;
		logic               in_rel_toggle;
		logic               in_rel_acked;
		logic               fatal;
		logic [LEN_W-1:0]   reliable_length;
		logic [CLEAR_W-1:0] clear_time;
		logic [WORD_W-1:0]  drops;
		logic [WORD_W-1:0]  goods;
		logic [WORD_W-1:0]  chokes;
	} state_t;

endpackage
`default_nettype wire

@@ hw/rtl/rdc_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
`default_nettype none
interface rdc_req_if;
	logic          valid;
	logic          ready;
	rdc_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rdc_rsp_if;
	logic          valid;
	logic          ready;
	rdc_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rdc_step.sv @@
// Combinational next-state and response logic for one channel request.
`default_nettype none
module rdc_step #(
	parameter int DATAGRAM_BYTES = 1024
) (
	input  rdc_pkg::state_t                 st,
	input  logic [rdc_pkg::COST_W-1:0]      byte_cost,
	input  logic [rdc_pkg::CHOKE_W-1:0]     choke_cost,
	input  rdc_pkg::req_t                   item,
	output rdc_pkg::state_t                 nxt,
	output rdc_pkg::rsp_t                   res,
	output logic                            clr_cost
);

	localparam int SZW = $clog2(DATAGRAM_BYTES + 2056);
	localparam logic [SZW-1:0] DB  = SZW'(DATAGRAM_BYTES);
	localparam logic [SZW-1:0] HDR = SZW'(rdc_pkg::HDR_BYTES);

	logic                            rel_resend;
	logic                            take;
	logic                            send_rel;
	logic [rdc_pkg::LEN_W-1:0]       plen_sat;
	logic [rdc_pkg::LEN_W-1:0]       rel_len;
	logic [SZW-1:0]                  size_rel;
	logic [SZW-1:0]                  size_a;
	logic [SZW-1:0]                  ulen;
	logic                            fits;
	logic [SZW-1:0]                  size;
	logic [SZW+rdc_pkg::COST_W-1:0]  cost;
	logic [rdc_pkg::CLEAR_W-1:0]     now_ext;
	logic [rdc_pkg::CLEAR_W-1:0]     base;
	logic [rdc_pkg::WORD_W:0]        limit;
	logic                            send_allowed;
	logic [rdc_pkg::SEQ_W-1:0]       rx_seq;
	logic                            rx_new;
	logic                            rx_gap;

	always_comb begin
		rel_resend = (st.in_seq > st.last_rel_out_seq) && (st.in_rel_toggle != st.in_rel_acked);
		take       = (st.reliable_length == '0) && (item.pending_length != '0);
		plen_sat   = (SZW'(item.pending_length) > DB) ? DB[rdc_pkg::LEN_W-1:0]
		                                              : item.pending_length;
		rel_len    = take ? plen_sat : st.reliable_length;
		send_rel   = rel_resend || take;
		size_rel   = HDR + SZW'(rel_len);
		size_a     = send_rel ? ((size_rel > DB) ? DB : size_rel) : HDR;
		ulen       = SZW'(item.unreliable_length);
		fits       = (DB - size_a) >= ulen;
		size       = fits ? (size_a + ulen) : size_a;
		cost       = (SZW+rdc_pkg::COST_W)'(size) * (SZW+rdc_pkg::COST_W)'(byte_cost);
		now_ext    = rdc_pkg::CLEAR_W'(item.current_time);
		base       = (st.clear_time < now_ext) ? now_ext : st.clear_time;

		limit        = (rdc_pkg::WORD_W+1)'(item.current_time)
		             + (rdc_pkg::WORD_W+1)'(choke_cost);
		send_allowed = st.clear_time < rdc_pkg::CLEAR_W'(limit);

		rx_seq = item.seq_word[rdc_pkg::SEQ_W-1:0];
		rx_new = rx_seq > st.in_seq;
		rx_gap = {1'b0, rx_seq} > ({1'b0, st.in_seq} + 32'd1);

		nxt      = st;
		res      = '0;
		clr_cost = 1'b0;

		case (item.opcode)
			rdc_pkg::OP_SEND: begin
				if (item.pending_overflowed) begin
					nxt.fatal = 1'b1;
				end else begin
					if (take) begin
						nxt.reliable_length = plen_sat;
					end
					if (send_rel) begin
						nxt.last_rel_out_seq = st.out_seq;
					end
					nxt.out_seq    = st.out_seq + 31'd1;
					nxt.clear_time = base + rdc_pkg::CLEAR_W'(cost);
					res.ok                  = 1'b1;
					res.out_seq_word        = {send_rel, st.out_seq};
					res.out_ack_word        = {st.in_rel_toggle, st.in_seq};
					res.packet_length       = size[rdc_pkg::LEN_W-1:0];
					res.reliable_included   = send_rel;
					res.unreliable_included = fits;
					res.pending_taken       = take;
				end
			end
			rdc_pkg::OP_RECEIVE: begin
				if (rx_new) begin
					if (rx_gap) begin
						nxt.drops = st.drops + 32'd1;
					end
					if (item.ack_word[rdc_pkg::WORD_W-1] == st.in_rel_toggle) begin
						nxt.reliable_length = '0;
					end
					nxt.in_seq        = rx_seq;
					nxt.in_rel_acked  = item.ack_word[rdc_pkg::WORD_W-1];
					nxt.in_rel_toggle = st.in_rel_toggle ^ item.seq_word[rdc_pkg::WORD_W-1];
					nxt.goods         = st.goods + 32'd1;
					res.ok            = 1'b1;
				end
			end
			rdc_pkg::OP_CAN_SEND: begin
				res.ok = send_allowed;
				if (!send_allowed) begin
					nxt.chokes = st.chokes + 32'd1;
				end
			end
			rdc_pkg::OP_CAN_SEND_REL: begin
				if (st.reliable_length == '0) begin
					res.ok = send_allowed;
					if (!send_allowed) begin
						nxt.chokes = st.chokes + 32'd1;
					end
				end
			end
			rdc_pkg::OP_CHAN_RESET: begin
				nxt                 = '0;
				nxt.reliable_length = st.reliable_length;
				clr_cost            = 1'b1;
				res.ok              = 1'b1;
			end
			default: begin
				nxt = st;
			end
		endcase

		res.fatal_error = nxt.fatal;
		res.drop_count  = nxt.drops;
		res.good_count  = nxt.goods;
		res.choke_count = nxt.chokes;
	end

endmodule
`default_nettype wire

@@ hw/rtl/reliable_datagram_channel_core.sv @@
// Top level of the reliable datagram channel header and bandwidth core.
//
// Requests arrive on the req channel (send, receive, can_send,
// can_send_reliable, channel reset) and each one yields exactly one response
// on the rsp channel, in order. A request is taken into an input register,
// evaluated against the channel state in a single combinational pass and
// written into the response register together with the state update.
// Responses leave from the response register. Throughput is one request per
// cycle while the receiver does not stall; it is set by the registered state
// update, which the next request reads directly. When the receiver stalls,
// the response register holds and the input register holds one further
// request; req.ready drops only when both are full. The byte cost register
// is written through cfg_we/cfg_wdata; the user must write it only while the
// core is idle, which the block does not enforce. The choke threshold of 200
// packets is precomputed on write. Asynchronous reset clears all channel
// state, the byte cost and both stage valid flags. There are no memories and no clearing pass.
`default_nettype none
module reliable_datagram_channel_core #(
	parameter int DATAGRAM_BYTES = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rdc_pkg::COST_W-1:0]  cfg_wdata,
	rdc_req_if.sink                          req,
	rdc_rsp_if.source                        rsp
);

	rdc_pkg::req_t                   req_s1;
	logic                            valid_s1;
	rdc_pkg::state_t                 state_q;
	logic [rdc_pkg::COST_W-1:0]      byte_cost_q;
	logic [rdc_pkg::CHOKE_W-1:0]     choke_cost_q;
	rdc_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;

	rdc_pkg::state_t                 state_n;
	rdc_pkg::rsp_t                   rsp_n;
	logic                            clr_cost;
	logic                            advance;
	logic                            fire;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	rdc_step #(
		.DATAGRAM_BYTES(DATAGRAM_BYTES)
	) u_step (
		.st        (state_q),
		.byte_cost (byte_cost_q),
		.choke_cost(choke_cost_q),
		.item      (req_s1),
		.nxt       (state_n),
		.res       (rsp_n),
		.clr_cost  (clr_cost)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			state_q      <= '0;
			byte_cost_q  <= '0;
			choke_cost_q <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			if (fire) begin
				state_q <= state_n;
			end
			if (fire && clr_cost) begin
				byte_cost_q  <= '0;
				choke_cost_q <= '0;
			end else if (cfg_we) begin
				byte_cost_q  <= cfg_wdata;
				choke_cost_q <= rdc_pkg::CHOKE_W'(cfg_wdata)
				              * rdc_pkg::CHOKE_W'(rdc_pkg::BACKUP_PACKETS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
		if (fire) begin
			rsp_q <= rsp_n;
		end
	end

	a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("evaluated request did not produce a response");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(req_s1)))
		else $error("stalled input stage lost its request");

	a_out_seq_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q.out_seq))
		else $error("outgoing sequence changed without a request");

	a_good_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rsp_n.ok && (req_s1.opcode == rdc_pkg::OP_RECEIVE))
		|=> (state_q.goods == $past(state_q.goods) + 32'd1))
		else $error("accepted receive did not advance the good count");

endmodule
`default_nettype wire
